FILE: sv/gf25_pkg.sv
package gf25_pkg;

  // GF(25) element as two GF(5) digits: value = re + im*s, s*s = 2
  typedef struct packed {
    logic [2:0] im;
    logic [2:0] re;
  } gf_t;

  typedef struct packed {
    gf_t c0;
    gf_t c1;
    gf_t c2;
  } vec_t;

  localparam int unsigned InW   = 32;
  localparam int unsigned OutW  = 40;
  localparam int unsigned KeyW  = 14;
  localparam logic [KeyW-1:0] KeyMul1 = 14'd25;
  localparam logic [KeyW-1:0] KeyMul2 = 14'd625;

  typedef enum logic [1:0] {
    KIND_JOIN = 2'd0,
    KIND_DOT  = 2'd1,
    KIND_NORM = 2'd2,
    KIND_FROB = 2'd3
  } kind_t;

  function automatic logic [2:0] add5(logic [2:0] a, logic [2:0] b);
    logic [3:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 4'd5) s = s - 4'd5;
    return s[2:0];
  endfunction

  function automatic logic [2:0] neg5(logic [2:0] a);
    return (a == 3'd0) ? 3'd0 : 3'd5 - a;
  endfunction

  function automatic logic [2:0] mul5(logic [2:0] a, logic [2:0] b);
    logic [4:0] p;
    p = {2'b00, a} * {2'b00, b};
    if (p >= 5'd15)      p = p - 5'd15;
    else if (p >= 5'd10) p = p - 5'd10;
    else if (p >= 5'd5)  p = p - 5'd5;
    return p[2:0];
  endfunction

  function automatic logic [2:0] inv5(logic [2:0] a);
    logic [2:0] r;
    unique case (a)
      3'd1:    r = 3'd1;
      3'd2:    r = 3'd3;
      3'd3:    r = 3'd2;
      3'd4:    r = 3'd4;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic gf_t gf_add(gf_t x, gf_t y);
    gf_t r;
    r.re = add5(x.re, y.re);
    r.im = add5(x.im, y.im);
    return r;
  endfunction

  function automatic gf_t gf_sub(gf_t x, gf_t y);
    gf_t r;
    r.re = add5(x.re, neg5(y.re));
    r.im = add5(x.im, neg5(y.im));
    return r;
  endfunction

  function automatic gf_t gf_mul(gf_t x, gf_t y);
    gf_t r;
    logic [2:0] bd;
    bd   = mul5(x.im, y.im);
    r.re = add5(mul5(x.re, y.re), add5(bd, bd));
    r.im = add5(mul5(x.re, y.im), mul5(x.im, y.re));
    return r;
  endfunction

  function automatic gf_t gf_conj(gf_t x);
    gf_t r;
    r.re = x.re;
    r.im = neg5(x.im);
    return r;
  endfunction

  // 1/(a+bs) = (a-bs)/(a^2-2b^2); zero maps to zero
  function automatic gf_t gf_inv(gf_t x);
    gf_t r;
    logic [2:0] bb;
    logic [2:0] ni;
    bb   = mul5(x.im, x.im);
    ni   = inv5(add5(mul5(x.re, x.re), neg5(add5(bb, bb))));
    r.re = mul5(x.re, ni);
    r.im = mul5(neg5(x.im), ni);
    return r;
  endfunction

  // code mod 25, then split into digits
  function automatic gf_t gf_decode(logic [4:0] code);
    gf_t r;
    logic [4:0] v;
    v = (code >= 5'd25) ? code - 5'd25 : code;
    if (v >= 5'd20) begin
      r.im = 3'd4;
      v    = v - 5'd20;
    end else if (v >= 5'd15) begin
      r.im = 3'd3;
      v    = v - 5'd15;
    end else if (v >= 5'd10) begin
      r.im = 3'd2;
      v    = v - 5'd10;
    end else if (v >= 5'd5) begin
      r.im = 3'd1;
      v    = v - 5'd5;
    end else begin
      r.im = 3'd0;
    end
    r.re = v[2:0];
    return r;
  endfunction

  function automatic logic [4:0] gf_encode(gf_t x);
    return {2'b00, x.re} + {x.im, 2'b00} + {2'b00, x.im};
  endfunction

  function automatic logic gf_is_zero(gf_t x);
    return (x.re == 3'd0) && (x.im == 3'd0);
  endfunction

endpackage

FILE: sv/gf25_projective_point_unit.sv
// Throughput: one beat per cycle; the five-stage pipeline moves as one unit and
//   holds in place only while the output beat waits on out_tready.
// Reset: rst_n, synchronous, active low, empties the pipeline; no other state.
module gf25_projective_point_unit import gf25_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  // fields from bit 0: p0[4:0], p1, p2, q0, q1, q2 (5 bits each), zero pad
  input  logic [InW-1:0]  in_tdata,
  // kind[1:0]: 0 join, 1 dot, 2 normalize, 3 frobenius
  input  logic [1:0]      in_tuser,
  output logic            out_tvalid,
  input  logic            out_tready,
  // fields from bit 0: r0[4:0], r1, r2, dot_value[4:0], incident, zero_vector,
  // packed_key[13:0], zero pad
  output logic [OutW-1:0] out_tdata
);

  // Whole pipeline advances together; a waiting output freezes every stage.
  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // Stage 1: decode codes into GF(5) digit pairs
  logic  s1_valid_r;
  kind_t s1_kind_r;
  vec_t  s1_p_r, s1_q_r;

  // Stage 2: cross product, copied or conjugated vector, dot product
  logic  s2_valid_r;
  logic  s2_norm_r;
  vec_t  s2_v_r;
  gf_t   s2_dot_r;
  vec_t  s2_v_nxt;
  gf_t   s2_dot_nxt;

  // Stage 3: leading coordinate inverse
  logic  s3_valid_r;
  logic  s3_zero_r;
  vec_t  s3_v_r;
  gf_t   s3_inv_r;
  gf_t   s3_dot_r;
  gf_t   lead;

  // Stage 4: scaled vector
  logic  s4_valid_r;
  logic  s4_zero_r;
  vec_t  s4_v_r;
  gf_t   s4_dot_r;

  // Stage 5: coded output beat
  logic [OutW-1:0] out_data_r;
  logic            out_valid_r;
  logic [4:0]      r0_c, r1_c, r2_c, dot_c;
  logic [KeyW-1:0] key_c;

  always_comb begin
    s2_dot_nxt = gf_add(gf_add(gf_mul(s1_p_r.c0, s1_q_r.c0), gf_mul(s1_p_r.c1, s1_q_r.c1)),
                        gf_mul(s1_p_r.c2, s1_q_r.c2));
    s2_v_nxt   = '0;
    unique case (s1_kind_r)
      KIND_JOIN: begin
        s2_v_nxt.c0 = gf_sub(gf_mul(s1_p_r.c1, s1_q_r.c2), gf_mul(s1_p_r.c2, s1_q_r.c1));
        s2_v_nxt.c1 = gf_sub(gf_mul(s1_p_r.c2, s1_q_r.c0), gf_mul(s1_p_r.c0, s1_q_r.c2));
        s2_v_nxt.c2 = gf_sub(gf_mul(s1_p_r.c0, s1_q_r.c1), gf_mul(s1_p_r.c1, s1_q_r.c0));
      end
      KIND_NORM: s2_v_nxt = s1_p_r;
      KIND_FROB: begin
        s2_v_nxt.c0 = gf_conj(s1_p_r.c0);
        s2_v_nxt.c1 = gf_conj(s1_p_r.c1);
        s2_v_nxt.c2 = gf_conj(s1_p_r.c2);
      end
      default: s2_v_nxt = '0; // dot: no vector result
    endcase
  end

  // first nonzero coordinate; an all-zero vector leaves lead zero
  always_comb begin
    priority if (!gf_is_zero(s2_v_r.c0)) lead = s2_v_r.c0;
    else if (!gf_is_zero(s2_v_r.c1))     lead = s2_v_r.c1;
    else                                 lead = s2_v_r.c2;
  end

  always_comb begin
    r0_c  = gf_encode(s4_v_r.c0);
    r1_c  = gf_encode(s4_v_r.c1);
    r2_c  = gf_encode(s4_v_r.c2);
    dot_c = gf_encode(s4_dot_r);
    key_c = KeyW'(r0_c) + KeyW'(r1_c) * KeyMul1 + KeyW'(r2_c) * KeyMul2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= in_tvalid;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      out_valid_r <= s4_valid_r;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_kind_r <= kind_t'(in_tuser);
      s1_p_r.c0 <= gf_decode(in_tdata[4:0]);
      s1_p_r.c1 <= gf_decode(in_tdata[9:5]);
      s1_p_r.c2 <= gf_decode(in_tdata[14:10]);
      s1_q_r.c0 <= gf_decode(in_tdata[19:15]);
      s1_q_r.c1 <= gf_decode(in_tdata[24:20]);
      s1_q_r.c2 <= gf_decode(in_tdata[29:25]);

      s2_norm_r <= (s1_kind_r != KIND_DOT);
      s2_v_r    <= s2_v_nxt;
      s2_dot_r  <= s2_dot_nxt;

      s3_zero_r <= s2_norm_r && gf_is_zero(lead);
      s3_v_r    <= s2_v_r;
      s3_inv_r  <= gf_inv(lead);
      s3_dot_r  <= s2_dot_r;

      // zero vector scales to zero, so no extra masking
      s4_zero_r <= s3_zero_r;
      s4_v_r.c0 <= gf_mul(s3_v_r.c0, s3_inv_r);
      s4_v_r.c1 <= gf_mul(s3_v_r.c1, s3_inv_r);
      s4_v_r.c2 <= gf_mul(s3_v_r.c2, s3_inv_r);
      s4_dot_r  <= s3_dot_r;

      out_data_r <= {4'b0000, key_c, s4_zero_r, gf_is_zero(s4_dot_r), dot_c, r2_c, r1_c, r0_c};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
